FILE: rtl/core/tht_pkg.sv
package tht_pkg;

    localparam int MAP_W     = 32;
    localparam int MAP_BIT_W = 5;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic [1:0] HANDLE_MARK_BITS = 2'b01;
    localparam logic [5:0] HANDLE_LOW_CODE  = 6'd2;

    typedef struct packed {
        logic                 found;
        logic [MAP_BIT_W-1:0] bit_pos;
    } t_find;

    typedef struct packed {
        logic [3:0]  obj_type;
        logic [31:0] payload;
    } t_slot;

endpackage

FILE: rtl/core/tht_slot_mem.sv
module tht_slot_mem #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    output tht_pkg::t_slot                 o_rd_data,
    input  logic                           i_wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  tht_pkg::t_slot                 i_wr_data
);
    import tht_pkg::*;

    t_slot r_mem [TABLE_DEPTH];
    t_slot r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

FILE: rtl/core/tht_free_map.sv
module tht_free_map #(
    parameter int TABLE_DEPTH = 1024,
    parameter int WORDS       = (TABLE_DEPTH + tht_pkg::MAP_W - 1) / tht_pkg::MAP_W,
    parameter int WORD_W      = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic                          i_clk,
    input  logic [WORD_W-1:0]             i_rd_addr,
    input  logic                          i_first,
    input  logic [tht_pkg::MAP_BIT_W-1:0] i_start_bit,
    output logic [tht_pkg::MAP_W-1:0]     o_rd_word,
    output tht_pkg::t_find                o_find,
    input  logic                          i_wr_en,
    input  logic [WORD_W-1:0]             i_wr_addr,
    input  logic [tht_pkg::MAP_W-1:0]     i_wr_data
);
    import tht_pkg::*;

    localparam int REM = TABLE_DEPTH % MAP_W;
    localparam logic [MAP_W-1:0] LAST_MASK =
        (REM == 0) ? {MAP_W{1'b1}} : ((MAP_W'(1) << REM) - MAP_W'(1));

    logic [MAP_W-1:0]  r_mem [WORDS];
    logic [MAP_W-1:0]  r_rd;
    logic [WORD_W-1:0] r_rd_addr;
    logic [MAP_W-1:0]  valid_mask;
    logic [MAP_W-1:0]  first_mask;
    logic [MAP_W-1:0]  free_vec;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd      <= r_mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    always_comb begin
        valid_mask = (r_rd_addr == WORD_W'(WORDS - 1)) ? LAST_MASK : {MAP_W{1'b1}};
        first_mask = i_first ? ~((MAP_W'(1) << i_start_bit) - MAP_W'(1)) : {MAP_W{1'b1}};
        free_vec   = ~r_rd & valid_mask & first_mask;
        o_find.found   = |free_vec;
        o_find.bit_pos = '0;
        for (int b = MAP_W - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                o_find.bit_pos = MAP_BIT_W'(b);
            end
        end
    end

    assign o_rd_word = r_rd;

endmodule

FILE: rtl/core/typed_handle_table.sv
// Allocate scans one occupancy word per cycle from the next-fit start. A full table, an
// out-of-range handle, a malformed handle on lookup or an unknown mode goes straight to the
// response. The next item is taken once the result enters the output register, which waits
// while a held result is not yet taken. Reset: synchronous, active low; a clearing pass then
// writes WORDS zero words into the occupancy memory (32 at the default depth), o_s_tready low.
module typed_handle_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // handle_in[31:0], object_type[35:32], payload_in[67:36], zero pad
    input  logic [1:0]  i_s_tuser,  // mode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata   // handle_out[30:0], payload_out[62:31], status[64:63], zero pad
);
    import tht_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WORDS  = (TABLE_DEPTH + MAP_W - 1) / MAP_W;
    localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FREE  = 3'd3;
    localparam logic [2:0] S_LOOK  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [WORD_W-1:0]    r_clr, n_clr;
    logic [IDX_W-1:0]     r_start, n_start;
    logic [CNT_W-1:0]     r_used, n_used;
    logic                 r_first, n_first;
    logic [WORD_W-1:0]    r_word, n_word;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [MAP_BIT_W-1:0] r_bit, n_bit;
    logic [3:0]           r_type, n_type;
    logic [31:0]          r_pay, n_pay;
    logic [30:0]          r_res_handle, n_res_handle;
    logic [31:0]          r_res_pay, n_res_pay;
    logic [1:0]           r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    logic [30:0]          r_out_handle, n_out_handle;
    logic [31:0]          r_out_pay, n_out_pay;
    logic [1:0]           r_out_status, n_out_status;

    logic                 in_accept;
    logic [1:0]           f_mode;
    logic [31:0]          f_handle;
    logic [23:0]          f_hidx;
    logic                 f_in_range;
    logic                 f_exact;
    logic [23:0]          start24;
    logic [IDX_W-1:0]     fidx;

    logic [MAP_W-1:0]     map_rd_word;
    t_find                map_find;
    logic                 map_wr_en;
    logic [WORD_W-1:0]    map_wr_addr;
    logic [MAP_W-1:0]     map_wr_data;
    t_slot                slot_rd;
    logic                 slot_wr_en;
    t_slot                slot_wr_data;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign f_mode     = i_s_tuser;
    assign f_handle   = i_s_tdata[31:0];
    assign f_hidx     = f_handle[29:6];
    assign f_in_range = ({1'b0, f_hidx} < 25'(TABLE_DEPTH));
    assign f_exact    = (f_handle[31:30] == HANDLE_MARK_BITS) && (f_handle[5:0] == HANDLE_LOW_CODE);
    assign start24    = 24'(r_start);
    assign fidx       = IDX_W'({r_word, map_find.bit_pos});

    tht_free_map #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WORDS       (WORDS),
        .WORD_W      (WORD_W)
    ) u_free_map (
        .i_clk       (i_clk),
        .i_rd_addr   (n_word),
        .i_first     (r_first),
        .i_start_bit (start24[MAP_BIT_W-1:0]),
        .o_rd_word   (map_rd_word),
        .o_find      (map_find),
        .i_wr_en     (map_wr_en),
        .i_wr_addr   (map_wr_addr),
        .i_wr_data   (map_wr_data)
    );

    tht_slot_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_slot_mem (
        .i_clk       (i_clk),
        .i_rd_addr   (n_idx),
        .o_rd_data   (slot_rd),
        .i_wr_en     (slot_wr_en),
        .i_wr_addr   (fidx),
        .i_wr_data   (slot_wr_data)
    );

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_start      = r_start;
        n_used       = r_used;
        n_first      = r_first;
        n_word       = r_word;
        n_idx        = r_idx;
        n_bit        = r_bit;
        n_type       = r_type;
        n_pay        = r_pay;
        n_res_handle = r_res_handle;
        n_res_pay    = r_res_pay;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_handle = r_out_handle;
        n_out_pay    = r_out_pay;
        n_out_status = r_out_status;
        map_wr_en    = 1'b0;
        map_wr_addr  = r_word;
        map_wr_data  = map_rd_word;
        slot_wr_en   = 1'b0;
        slot_wr_data = '{obj_type: r_type, payload: r_pay};

        unique case (r_state)
            S_CLEAR: begin
                map_wr_en   = 1'b1;
                map_wr_addr = r_clr;
                map_wr_data = '0;
                n_clr       = r_clr + WORD_W'(1);
                if (r_clr == WORD_W'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_type       = i_s_tdata[35:32];
                    n_pay        = i_s_tdata[67:36];
                    n_bit        = f_hidx[MAP_BIT_W-1:0];
                    n_res_handle = '0;
                    n_res_pay    = '0;
                    n_res_status = ST_BAD;
                    n_state      = S_RESP;
                    unique case (f_mode)
                        MODE_ALLOC: begin
                            if (r_used == CNT_W'(TABLE_DEPTH)) begin
                                n_res_status = ST_NOMEM;
                            end else begin
                                n_word  = WORD_W'(start24 >> MAP_BIT_W);
                                n_first = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        MODE_FREE: begin
                            if (f_in_range) begin
                                n_word  = WORD_W'(f_hidx >> MAP_BIT_W);
                                n_state = S_FREE;
                            end
                        end
                        MODE_LOOKUP: begin
                            if (f_in_range && f_exact) begin
                                n_word  = WORD_W'(f_hidx >> MAP_BIT_W);
                                n_idx   = IDX_W'(f_hidx);
                                n_state = S_LOOK;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_first = 1'b0;
                if (map_find.found) begin
                    map_wr_en    = 1'b1;
                    map_wr_data  = map_rd_word | (MAP_W'(1) << map_find.bit_pos);
                    slot_wr_en   = 1'b1;
                    n_start      = (fidx == IDX_W'(TABLE_DEPTH - 1)) ? '0 : fidx + IDX_W'(1);
                    n_used       = r_used + CNT_W'(1);
                    n_res_handle = {1'b1, 24'(fidx), HANDLE_LOW_CODE};
                    n_res_status = ST_OK;
                    n_state      = S_RESP;
                end else begin
                    n_word = (r_word == WORD_W'(WORDS - 1)) ? '0 : r_word + WORD_W'(1);
                end
            end
            S_FREE: begin
                map_wr_en   = 1'b1;
                map_wr_data = map_rd_word & ~(MAP_W'(1) << r_bit);
                if (map_rd_word[r_bit]) begin
                    n_used = r_used - CNT_W'(1);
                end
                n_res_status = ST_OK;
                n_state      = S_RESP;
            end
            S_LOOK: begin
                if (map_rd_word[r_bit] && (slot_rd.obj_type == r_type)) begin
                    n_res_pay    = slot_rd.payload;
                    n_res_status = ST_OK;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_handle = r_res_handle;
                    n_out_pay    = r_res_pay;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_start     <= '0;
            r_used      <= '0;
            r_first     <= 1'b0;
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_start     <= n_start;
            r_used      <= n_used;
            r_first     <= n_first;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_bit        <= n_bit;
        r_type       <= n_type;
        r_pay        <= n_pay;
        r_res_handle <= n_res_handle;
        r_res_pay    <= n_res_pay;
        r_res_status <= n_res_status;
        r_out_handle <= n_out_handle;
        r_out_pay    <= n_out_pay;
        r_out_status <= n_out_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_status, r_out_pay, r_out_handle};

endmodule
